FILE: sv/multichannel_pwm_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel PWM generator
// Clocked property checks shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PWM_GENERATOR_TOP_ASSERT_SVH
`define MULTICHANNEL_PWM_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPWM_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MPWM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: sv/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and fixed field widths of the multichannel PWM generator.
// ----------------------------------------------------------------------------
package mpwm_pkg;

   localparam int DUTY_IN_W = 16;
   localparam int CHAN_W    = 4;
   localparam int LEVEL_W   = 16;
   localparam int INDEX_W   = 7;

   // full scale of a requested duty
   localparam logic [DUTY_IN_W-1:0] FULL_SCALE = 16'hFFFF;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   // per-transfer command from the pipeline to the channel bank
   typedef struct packed {
      logic tick_go;
      logic write_go;
   } mpwm_ctl_type;

endpackage

FILE: sv/multichannel_pwm_generator_top.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_generator_top
// PWM generator with shadow duty registers: duty writes and ticks in,
// one level word per transfer out.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_kind, req_channel, req_duty_value
//   rsp      out        rsp_valid/rsp_stall   rsp_pin_levels, rsp_tick_index
//
// One transfer per cycle sustained while rsp_stall is low: an input register and a
// result register, with the scale multiply and the per-channel compares between them.
// An accepted req transfer passes the input register, then the result register, to rsp_valid.
// Reset clears the tick count, all compares and the levels, and sets the
// update flag; no clearing pass, req is accepted in the first cycle after.
// rsp_stall holds the result register; req_stall rises only while the input
// register is full and the result register cannot drain.
// ----------------------------------------------------------------------------
module multichannel_pwm_generator_top
   import mpwm_pkg::*;
#(
   parameter int CHANNELS   = 16,
   parameter int RESOLUTION = 102
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [CHAN_W-1:0]    req_channel,
   input  logic [DUTY_IN_W-1:0] req_duty_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LEVEL_W-1:0]   rsp_pin_levels,
   output logic [INDEX_W-1:0]   rsp_tick_index
);

   // compares and tick position share one width: both span 0..RESOLUTION
   localparam int DUTY_W = $clog2(RESOLUTION + 1);

   // input register
   logic                 in_valid_ff;
   logic                 in_kind_ff;
   logic [CHAN_W-1:0]    in_channel_ff;
   logic [DUTY_IN_W-1:0] in_duty_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [LEVEL_W-1:0]   rsp_pin_ff,   rsp_pin_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;

   logic                 advance_ok;
   logic                 advance;
   mpwm_ctl_type         ctl;
   logic [DUTY_W-1:0]    duty_scaled;
   logic [DUTY_W-1:0]    tick_value;
   logic [CHANNELS-1:0]  levels_next;
   logic [CHANNELS-1:0]  levels_held;
   logic [CHANNELS-1:0]  levels_sel;
   logic [CHANNELS+LEVEL_W-1:0] levels_wide;
   logic [DUTY_W+INDEX_W-1:0]   index_wide;

   // result register can take a new item when empty or draining this cycle
   assign advance_ok = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && advance_ok;
   assign req_stall  = in_valid_ff && !advance_ok;

   always_comb begin
      ctl.tick_go  = advance && (in_kind_ff == KIND_TICK);
      ctl.write_go = advance && (in_kind_ff == KIND_WRITE);
   end

   mpwm_scale #(
      .RESOLUTION (RESOLUTION),
      .DUTY_W     (DUTY_W)
   ) u_scale (
      .duty_value  (in_duty_ff),
      .duty_scaled (duty_scaled)
   );

   mpwm_bank #(
      .CHANNELS   (CHANNELS),
      .RESOLUTION (RESOLUTION),
      .DUTY_W     (DUTY_W)
   ) u_bank (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .wr_channel  (in_channel_ff),
      .wr_duty     (duty_scaled),
      .tick_value  (tick_value),
      .levels_next (levels_next),
      .levels_held (levels_held)
   );

   // a duty write reports the held levels and the position of the next tick;
   // a tick reports the fresh levels and its own position
   always_comb begin
      levels_sel   = (in_kind_ff == KIND_WRITE) ? levels_held : levels_next;
      levels_wide  = {LEVEL_W'(0), levels_sel};
      index_wide   = {INDEX_W'(0), tick_value};
      rsp_pin_in   = levels_wide[LEVEL_W-1:0];
      rsp_index_in = index_wide[INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load the input register whenever it is free or moving on
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance_ok) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff    <= req_kind;
         in_channel_ff <= req_channel;
         in_duty_ff    <= req_duty_value;
      end
      if (advance) begin
         rsp_pin_ff   <= rsp_pin_in;
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_levels = rsp_pin_ff;
   assign rsp_tick_index = rsp_index_ff;

`include "multichannel_pwm_generator_top_assert.svh"

   `MPWM_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && rsp_valid_ff)
   `MPWM_ASSERT_NEXT(a_advance_fills_result, clock, reset, advance, rsp_valid_ff)
   `MPWM_ASSERT_NOW(a_index_in_period, clock, reset, rsp_valid, rsp_tick_index <= RESOLUTION)

endmodule

FILE: sv/mpwm_scale.sv
// ----------------------------------------------------------------------------
// mpwm_scale
// Scales a 16-bit duty to duty*RESOLUTION/65535, truncated.
// ----------------------------------------------------------------------------
module mpwm_scale
   import mpwm_pkg::*;
#(
   parameter int RESOLUTION = 102,
   parameter int DUTY_W     = 7
) (
   input  logic [DUTY_IN_W-1:0] duty_value,
   output logic [DUTY_W-1:0]    duty_scaled
);

   localparam int PROD_W = DUTY_IN_W + DUTY_W;

   logic [PROD_W-1:0]    product;
   logic [DUTY_W-1:0]    quot_est;
   logic [DUTY_IN_W:0]   remainder;
   logic [DUTY_W:0]      quot_fix;

   // x / 65535: estimate x >> 16, remainder is low half plus estimate,
   // which stays below twice the divisor, so one correction step suffices
   always_comb begin
      product     = PROD_W'(duty_value) * PROD_W'(RESOLUTION);
      quot_est    = product[PROD_W-1:DUTY_IN_W];
      remainder   = {1'b0, product[DUTY_IN_W-1:0]} + (DUTY_IN_W+1)'(quot_est);
      quot_fix    = {1'b0, quot_est} + (DUTY_W+1)'(remainder >= {1'b0, FULL_SCALE});
      duty_scaled = quot_fix[DUTY_W-1:0];
   end

endmodule

FILE: sv/mpwm_bank.sv
// ----------------------------------------------------------------------------
// mpwm_bank
// Tick counter, shadow and active compares, update flag and level register.
// ----------------------------------------------------------------------------
module mpwm_bank
   import mpwm_pkg::*;
#(
   parameter int CHANNELS   = 16,
   parameter int RESOLUTION = 102,
   parameter int DUTY_W     = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  mpwm_ctl_type        ctl,
   input  logic [CHAN_W-1:0]   wr_channel,
   input  logic [DUTY_W-1:0]   wr_duty,
   output logic [DUTY_W-1:0]   tick_value,
   output logic [CHANNELS-1:0] levels_next,
   output logic [CHANNELS-1:0] levels_held
);

   localparam int CMP_W = CHAN_W + 7;

   logic [DUTY_W-1:0]   tick_ff,    tick_in;
   logic [DUTY_W-1:0]   pending_ff [CHANNELS];
   logic [DUTY_W-1:0]   pending_in [CHANNELS];
   logic [DUTY_W-1:0]   active_ff  [CHANNELS];
   logic [DUTY_W-1:0]   active_in  [CHANNELS];
   logic                update_ff,  update_in;
   logic [CHANNELS-1:0] level_ff,   level_in;
   logic                load;
   logic                chan_ok;

   always_comb begin
      load    = ctl.tick_go && (tick_ff == '0) && update_ff;
      chan_ok = CMP_W'(wr_channel) < CMP_W'(CHANNELS);

      for (int i = 0; i < CHANNELS; i++) begin
         active_in[i]   = load ? pending_ff[i] : active_ff[i];
         levels_next[i] = active_in[i] > tick_ff;
         if (ctl.write_go && (CMP_W'(wr_channel) == CMP_W'(i))) begin
            pending_in[i] = wr_duty;
         end else begin
            pending_in[i] = pending_ff[i];
         end
      end

      update_in = update_ff;
      if (load) begin
         update_in = 1'b0;
      end
      if (ctl.write_go && chan_ok) begin
         update_in = 1'b1;
      end

      tick_in  = tick_ff;
      level_in = level_ff;
      if (ctl.tick_go) begin
         tick_in  = (tick_ff >= DUTY_W'(RESOLUTION)) ? '0 : tick_ff + 1'b1;
         level_in = levels_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         update_ff <= 1'b1;
         level_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            pending_ff[i] <= '0;
            active_ff[i]  <= '0;
         end
      end else begin
         tick_ff   <= tick_in;
         update_ff <= update_in;
         level_ff  <= level_in;
         for (int i = 0; i < CHANNELS; i++) begin
            pending_ff[i] <= pending_in[i];
            active_ff[i]  <= active_in[i];
         end
      end
   end

   assign tick_value  = tick_ff;
   assign levels_held = level_ff;

`include "multichannel_pwm_generator_top_assert.svh"

   `MPWM_ASSERT_NOW(a_tick_in_period, clock, reset, 1'b1, tick_ff <= DUTY_W'(RESOLUTION))
   `MPWM_ASSERT_NEXT(a_period_start_clears_flag, clock, reset, ctl.tick_go && (tick_ff == '0), !update_ff)
   `MPWM_ASSERT_NEXT(a_write_sets_flag, clock, reset, ctl.write_go && chan_ok, update_ff)

endmodule
